// ===== rtl/psc_pkg.sv =====
// psc_pkg: shared types and constants of the proper divisor sum classifier
// no dependencies; used by psc_rem_unit, psc_acc and the top level
`default_nettype none

package psc_pkg;

  // result field widths
  localparam int unsigned SumW   = 20;
  localparam int unsigned CountW = 7;

  localparam logic [SumW-1:0]   SumMax   = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LAUNCH = 4'b0010,
    S_DIV    = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  // status from the bit-serial remainder unit
  typedef struct packed {
    logic done;
    logic is_zero;
  } rem_sts_t;

  // control towards the accumulators
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/psc_rem_unit.sv =====
// psc_rem_unit: radix-2 restoring remainder, one dividend bit per cycle
// depends on psc_pkg (rem_sts_t)
`default_nettype none

module psc_rem_unit #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [NUMBER_BITS-1:0] dividend_i,
  input  wire logic [NUMBER_BITS-1:0] divisor_i,
  output psc_pkg::rem_sts_t           sts_o
);

  localparam int unsigned CntW = $clog2(NUMBER_BITS);

  logic [NUMBER_BITS-1:0] dvd_q, dvd_d;
  logic [NUMBER_BITS-1:0] div_q, div_d;
  logic [NUMBER_BITS-1:0] rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [NUMBER_BITS:0]   trial;
  logic [NUMBER_BITS:0]   diff;

  // bring down the next dividend bit and try the subtraction
  assign trial = {rem_q, dvd_q[NUMBER_BITS-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CntW'(NUMBER_BITS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[NUMBER_BITS-2:0], 1'b0};
      rem_d = diff[NUMBER_BITS] ? trial[NUMBER_BITS-1:0] : diff[NUMBER_BITS-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign sts_o.done    = done_q;
  assign sts_o.is_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ===== rtl/psc_acc.sv =====
// psc_acc: saturating divisor sum, divisor count and full-range sum for the test
// depends on psc_pkg (acc_ctl_t, SumW, CountW)
`default_nettype none

module psc_acc #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire psc_pkg::acc_ctl_t            ctl_i,
  input  wire logic [NUMBER_BITS-1:0]       divisor_i,
  input  wire logic [NUMBER_BITS-1:0]       number_i,
  output logic      [psc_pkg::SumW-1:0]     sum_o,
  output logic      [psc_pkg::CountW-1:0]   count_o,
  output logic                              abundant_o
);

  localparam int unsigned AddW  =
    ((NUMBER_BITS > psc_pkg::SumW) ? NUMBER_BITS : psc_pkg::SumW) + 1;
  // aliquot sum tracked to two bits above n, held at all ones beyond
  localparam int unsigned FullW = NUMBER_BITS + 2;

  logic [psc_pkg::SumW-1:0]   sum_q, sum_d;
  logic [psc_pkg::CountW-1:0] count_q, count_d;
  logic [FullW-1:0]           full_q, full_d;
  logic [AddW-1:0]            sum_ext;
  logic [FullW:0]             full_ext;

  assign sum_ext  = AddW'(sum_q) + AddW'(divisor_i);
  assign full_ext = (FullW + 1)'(full_q) + (FullW + 1)'(divisor_i);

  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    full_d  = full_q;
    if (ctl_i.clear) begin
      sum_d   = '0;
      count_d = '0;
      full_d  = '0;
    end else if (ctl_i.add) begin
      sum_d = (sum_ext > AddW'(psc_pkg::SumMax)) ? psc_pkg::SumMax
                                                  : sum_ext[psc_pkg::SumW-1:0];
      if (count_q != psc_pkg::CountMax) begin
        count_d = count_q + 1'b1;
      end
      full_d = full_ext[FullW] ? {FullW{1'b1}} : full_ext[FullW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      full_q  <= '0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      full_q  <= full_d;
    end
  end

  assign sum_o      = sum_q;
  assign count_o    = count_q;
  assign abundant_o = (full_q > FullW'(number_i));

endmodule

`default_nettype wire

// ===== rtl/proper_divisor_sum_classifier_unit.sv =====
// proper_divisor_sum_classifier_unit: aliquot sum and abundant number test
// depends on psc_pkg, psc_rem_unit and psc_acc
//
// usage
//   slave channel: one word per number, n in s_axis_tdata_i[NUMBER_BITS-1:0]
//   master channel: one word per number, divisor sum in m_axis_tdata_o[19:0],
//   divisor count in [26:20], abundant flag in m_axis_tuser_o
//   a word moves on a clock edge where tvalid and tready are both high
// operation
//   every trial divisor d = 1 .. n-1 goes through the bit-serial remainder
//   unit: S_LAUNCH starts it, the unit shifts in the dividend bit by bit and
//   S_DIV takes the remainder when the unit is done; n of 0 or 1 skips the trials
//   worst case for 16 bits: 65534 trials
//   one number is worked on at a time; s_axis_tready_o is high while idle
// stalls
//   the result sits in an output register; the next number is accepted while
//   it waits, and a finished result is held back only if the register is full
// reset
//   rst_ni clears the sequencer, the accumulators and the output valid
`default_nettype none

module proper_divisor_sum_classifier_unit #(
  parameter int unsigned NUMBER_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // slave side: number, zero-padded to whole bytes
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  input  wire logic [((NUMBER_BITS+7)/8)*8-1:0]    s_axis_tdata_i,  // number
  // master side
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  output logic [31:0]                              m_axis_tdata_o,  // divisor_sum, divisor_count
  output logic [0:0]                               m_axis_tuser_o   // is_abundant
);

  localparam int unsigned OutPad = 32 - psc_pkg::SumW - psc_pkg::CountW;

  psc_pkg::state_e          state_q, state_d;
  logic [NUMBER_BITS-1:0]   number_q, number_d;
  logic [NUMBER_BITS-1:0]   trial_q, trial_d;       // current trial divisor
  logic [NUMBER_BITS-1:0]   trial_next;
  psc_pkg::rem_sts_t        rem_sts;
  psc_pkg::acc_ctl_t        acc_ctl;
  logic                     rem_start;
  logic [psc_pkg::SumW-1:0]   sum;
  logic [psc_pkg::CountW-1:0] count;
  logic                     abundant;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic [psc_pkg::SumW-1:0]   out_sum_q, out_sum_d;
  logic [psc_pkg::CountW-1:0] out_count_q, out_count_d;
  logic                       out_abund_q, out_abund_d;
  logic                       out_free;
  logic                       in_take;

  assign in_take    = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free   = ~out_valid_q | m_axis_tready_i;
  assign trial_next = trial_q + 1'b1;

  psc_rem_unit #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rem_start),
    .dividend_i (number_q),
    .divisor_i  (trial_q),
    .sts_o      (rem_sts)
  );

  psc_acc #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (acc_ctl),
    .divisor_i  (trial_q),
    .number_i   (number_q),
    .sum_o      (sum),
    .count_o    (count),
    .abundant_o (abundant)
  );

  // sequencer
  always_comb begin
    state_d         = state_q;
    number_d        = number_q;
    trial_d         = trial_q;
    rem_start       = 1'b0;
    acc_ctl.clear   = 1'b0;
    acc_ctl.add     = 1'b0;
    out_valid_d     = out_valid_q & ~m_axis_tready_i;
    out_sum_d       = out_sum_q;
    out_count_d     = out_count_q;
    out_abund_d     = out_abund_q;
    s_axis_tready_o = (state_q == psc_pkg::S_IDLE);
    unique case (state_q)
      psc_pkg::S_IDLE: begin
        if (s_axis_tvalid_i) begin
          number_d      = s_axis_tdata_i[NUMBER_BITS-1:0];
          trial_d       = '0;
          acc_ctl.clear = 1'b1;
          // no trial divisor below two
          if (s_axis_tdata_i[NUMBER_BITS-1:1] == '0) begin
            state_d = psc_pkg::S_DONE;
          end else begin
            trial_d = NUMBER_BITS'(1);
            state_d = psc_pkg::S_LAUNCH;
          end
        end
      end
      psc_pkg::S_LAUNCH: begin
        rem_start = 1'b1;
        state_d   = psc_pkg::S_DIV;
      end
      psc_pkg::S_DIV: begin
        if (rem_sts.done) begin
          acc_ctl.add = rem_sts.is_zero;
          if (trial_next == number_q) begin
            state_d = psc_pkg::S_DONE;
          end else begin
            trial_d = trial_next;
            state_d = psc_pkg::S_LAUNCH;
          end
        end
      end
      psc_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = sum;
          out_count_d = count;
          out_abund_d = abundant;
          state_d     = psc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = psc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= psc_pkg::S_IDLE;
      trial_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      trial_q     <= trial_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    number_q    <= number_d;
    out_sum_q   <= out_sum_d;
    out_count_q <= out_count_d;
    out_abund_q <= out_abund_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{OutPad{1'b0}}, out_count_q, out_sum_q};
  assign m_axis_tuser_o  = out_abund_q;

  // remainder results only arrive while a trial is outstanding
  a_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_sts.done |-> (state_q == psc_pkg::S_DIV))
    else $error("remainder done outside trial state");

  // trial divisor stays a proper divisor candidate
  a_trial_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psc_pkg::S_DIV) |-> (trial_q < number_q && trial_q != '0))
    else $error("trial divisor out of range");

  // an accepted number always starts work
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> (state_q != psc_pkg::S_IDLE))
    else $error("accepted number left idle");

endmodule

`default_nettype wire

// ===== tb/tb_proper_divisor_sum_classifier_unit.sv =====
// tb_proper_divisor_sum_classifier_unit: self-checking bench for the aliquot sum unit
// depends on psc_pkg and proper_divisor_sum_classifier_unit; drives numbers in,
// predicts sum, count and abundant flag per number and checks every result word
`timescale 1ns / 100ps

module tb_proper_divisor_sum_classifier_unit;

  localparam int unsigned NumberBits    = 16;
  localparam int unsigned DataW         = ((NumberBits + 7) / 8) * 8;
  localparam int unsigned ClkPeriod     = 12;
  localparam int unsigned IdlePct       = 37;
  localparam int unsigned TimeoutCycles = 20_000_000;

  // one expected result word
  typedef struct packed {
    logic [psc_pkg::SumW-1:0]   sum;
    logic [psc_pkg::CountW-1:0] count;
    logic                       abundant;
  } aliquot_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             s_axis_tvalid_i = 1'b0;
  logic             s_axis_tready_o;
  logic [DataW-1:0] s_axis_tdata_i  = '0;
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i = 1'b0;
  logic [31:0]      m_axis_tdata_o;
  logic [0:0]       m_axis_tuser_o;

  aliquot_t    aliquot_q[$];
  int unsigned errors      = 0;
  int unsigned checked     = 0;
  int unsigned abundant_cnt = 0;
  int unsigned trivial_cnt = 0;
  int unsigned sent_cnt    = 0;
  bit          calm        = 1'b0;  // no idling on either side while set

  proper_divisor_sum_classifier_unit #(
    .NUMBER_BITS(NumberBits)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  // aliquot sum by trial division, saturating sum and count, flag on the full sum
  function automatic aliquot_t aliquot_of(input logic [NumberBits-1:0] n);
    aliquot_t        r;
    longint unsigned full_sum;
    longint unsigned num_div;
    longint unsigned d;
    full_sum = 0;
    num_div  = 0;
    for (d = 1; d < n; d++) begin
      if (n % d == 0) begin
        full_sum += d;
        num_div++;
      end
    end
    r.sum      = (full_sum > psc_pkg::SumMax) ? psc_pkg::SumMax
                                              : full_sum[psc_pkg::SumW-1:0];
    r.count    = (num_div > psc_pkg::CountMax) ? psc_pkg::CountMax
                                               : num_div[psc_pkg::CountW-1:0];
    r.abundant = (full_sum > n);
    return r;
  endfunction

  // send one number; valid stays high into the next call unless it idles first
  task automatic send_number(input logic [NumberBits-1:0] n);
    while (!calm && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= DataW'(n);
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    aliquot_q.insert(aliquot_q.size(), aliquot_of(n));
    sent_cnt++;
    if (n < 2) trivial_cnt++;
  endtask

  // result side: random back-pressure, off during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= IdlePct);
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    aliquot_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (aliquot_q.size() == 0) begin
        $display("%0t: result word with nothing expected, tdata %h tuser %b",
                 $time, m_axis_tdata_o, m_axis_tuser_o);
        errors++;
      end else begin
        want = aliquot_q.pop_front();
        checked++;
        if (want.abundant) abundant_cnt++;
        if (m_axis_tdata_o[psc_pkg::SumW-1:0] !== want.sum) begin
          $display("%0t: divisor_sum expected %0d actual %0d",
                   $time, want.sum, m_axis_tdata_o[psc_pkg::SumW-1:0]);
          errors++;
        end
        if (m_axis_tdata_o[psc_pkg::SumW+psc_pkg::CountW-1:psc_pkg::SumW] !== want.count)
        begin
          $display("%0t: divisor_count expected %0d actual %0d",
                   $time, want.count,
                   m_axis_tdata_o[psc_pkg::SumW+psc_pkg::CountW-1:psc_pkg::SumW]);
          errors++;
        end
        if (m_axis_tdata_o[31:psc_pkg::SumW+psc_pkg::CountW] !== '0) begin
          $display("%0t: tdata padding expected 0 actual %h",
                   $time, m_axis_tdata_o[31:psc_pkg::SumW+psc_pkg::CountW]);
          errors++;
        end
        if (m_axis_tuser_o[0] !== want.abundant) begin
          $display("%0t: is_abundant expected %0b actual %0b",
                   $time, want.abundant, m_axis_tuser_o[0]);
          errors++;
        end
      end
    end
  end

  // zero and one have no trial divisor; two and three have only 1
  task automatic test_trivial_numbers();
    send_number(0);
    send_number(1);
    send_number(2);
    send_number(3);
  endtask

  // primes give a sum of 1, powers of two fall one short of n
  task automatic test_primes_and_powers();
    send_number(7);
    send_number(251);
    send_number(4093);
    send_number(256);
    send_number(1024);
  endtask

  // perfect numbers sit on the boundary and must not be flagged
  task automatic test_perfect_and_abundant();
    send_number(6);
    send_number(12);
    send_number(18);
    send_number(28);
    send_number(496);
    send_number(945);   // first odd abundant
    send_number(720);
    send_number(5040);  // many divisors
  endtask

  // top of the range, every input bit high
  task automatic test_field_extremes();
    send_number({NumberBits{1'b1}});
  endtask

  // mostly small numbers to keep the trial loop short, a few larger ones
  task automatic test_random_numbers(input int unsigned count);
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 8)       send_number(NumberBits'($urandom_range(1, 0)));
      else if (pick < 95) send_number(NumberBits'($urandom_range(300, 2)));
      else                send_number(NumberBits'($urandom_range(4095, 301)));
    end
  endtask

  // both sides flat out, no idling at all
  task automatic test_back_to_back(input int unsigned count);
    calm = 1'b1;
    for (int unsigned i = 0; i < count; i++) begin
      send_number(NumberBits'($urandom_range(64, 0)));
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_trivial_numbers();
    test_primes_and_powers();
    test_perfect_and_abundant();
    test_field_extremes();
    test_random_numbers(67);
    test_back_to_back(15);

    s_axis_tvalid_i <= 1'b0;
    while (aliquot_q.size() != 0) @(posedge clk_i);
    // settle time in case a stray word is still on its way
    repeat (4 * (NumberBits + 1)) @(posedge clk_i);

    $display("covered %0d numbers (%0d of them zero or one), %0d result words checked,",
             sent_cnt, trivial_cnt, checked);
    $display("%0d abundant; extremes, primes, perfect numbers and back-to-back traffic",
             abundant_cnt);
    if (errors == 0 && aliquot_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d results outstanding", aliquot_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== proper_divisor_sum_classifier_unit.f =====
rtl/psc_pkg.sv
rtl/psc_rem_unit.sv
rtl/psc_acc.sv
rtl/proper_divisor_sum_classifier_unit.sv
tb/tb_proper_divisor_sum_classifier_unit.sv
